### design/rtt_pkg.sv
`timescale 1ns / 1ps

package rtt_pkg;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2,
    OP_HEARD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_QUEUED    = 3'd0,
    K_FULL      = 3'd1,
    K_ACKED     = 3'd2,
    K_UNMATCHED = 3'd3,
    K_RESEND    = 3'd4,
    K_FAILED    = 3'd5,
    K_SELF      = 3'd6,
    K_DONE      = 3'd7
  } kind_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SELF_ID    = 3'd0;
  localparam logic [2:0] CFG_DATA_WAIT  = 3'd1;
  localparam logic [2:0] CFG_DATA_TRIES = 3'd2;
  localparam logic [2:0] CFG_PING_WAIT  = 3'd3;
  localparam logic [2:0] CFG_PING_TRIES = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [15:0] peer;
    logic [31:0] seq;
    logic        ping;
    logic [3:0]  sends;
    logic [7:0]  ticks;
  } entry_t;

  typedef struct packed {
    logic [15:0] self_id;
    logic [7:0]  data_wait;
    logic [3:0]  data_tries;
    logic [7:0]  ping_wait;
    logic [3:0]  ping_max;
  } cfg_t;

  // Outcome of one entry visit.
  typedef struct packed {
    logic   wr;     // write the updated entry back
    entry_t nxt;    // updated entry
    logic   emit;   // produce a result word from nxt
    kind_e  kind;
    logic   hit;    // ack matched this entry
    logic   found;  // send took this free slot
  } step_t;

endpackage

### design/rtt_slot_unit.sv
`timescale 1ns / 1ps

module rtt_slot_unit
  import rtt_pkg::*;
(
  input  op_e         op_i,
  input  logic [15:0] peer_i,
  input  logic [31:0] ack_id_i,
  input  logic        is_ping_i,
  input  logic [31:0] new_seq_i,
  input  cfg_t        cfg_i,
  input  entry_t      entry_i,
  output step_t       step_o
);

  logic [7:0] wait_lim;
  logic [3:0] try_lim;
  logic       peer_eq;

  assign wait_lim = entry_i.ping ? cfg_i.ping_wait : cfg_i.data_wait;
  assign try_lim  = entry_i.ping ? cfg_i.ping_max  : cfg_i.data_tries;
  assign peer_eq  = (entry_i.peer == peer_i);

  always_comb begin
    step_o       = '0;
    step_o.nxt   = entry_i;
    step_o.kind  = K_DONE;
    case (op_i)
      OP_SEND: begin
        if (!entry_i.valid) begin
          step_o.wr        = 1'b1;
          step_o.nxt.valid = 1'b1;
          step_o.nxt.peer  = peer_i;
          step_o.nxt.seq   = new_seq_i;
          step_o.nxt.ping  = is_ping_i;
          step_o.nxt.sends = 4'd1;
          step_o.nxt.ticks = 8'd0;
          step_o.emit      = 1'b1;
          step_o.kind      = K_QUEUED;
          step_o.found     = 1'b1;
        end
      end
      OP_ACK: begin
        if (entry_i.valid && peer_eq && (entry_i.seq == ack_id_i)) begin
          step_o.wr        = 1'b1;
          step_o.nxt.valid = 1'b0;
          step_o.hit       = 1'b1;
        end
      end
      OP_TICK: begin
        if (entry_i.valid) begin
          step_o.wr = 1'b1;
          if (entry_i.ticks < wait_lim) begin
            step_o.nxt.ticks = entry_i.ticks + 8'd1;
          end else if (entry_i.sends < try_lim) begin
            step_o.nxt.sends = entry_i.sends + 4'd1;
            step_o.nxt.ticks = 8'd0;
            step_o.emit      = 1'b1;
            step_o.kind      = K_RESEND;
          end else begin
            step_o.nxt.valid = 1'b0;
            step_o.emit      = 1'b1;
            step_o.kind      = (entry_i.peer == cfg_i.self_id) ? K_SELF : K_FAILED;
          end
        end
      end
      OP_HEARD: begin
        if (entry_i.valid && peer_eq) begin
          step_o.wr = 1'b1;
          if (entry_i.ping) begin
            step_o.nxt.valid = 1'b0;
          end else begin
            step_o.nxt.sends = 4'd1;
          end
        end
      end
      default: begin
        step_o.wr = 1'b0;
      end
    endcase
  end

endmodule

### design/retransmit_timeout_table.sv
`timescale 1ns / 1ps

// Retransmission timer table. Holds up to TABLE_DEPTH outstanding sends in a
// single-port-write, registered-read entry memory that one entry-update unit
// sweeps in slot order, one entry per cycle while no result word waits on a
// stalled output. Every op (send, ack, tick, heard-from) walks the table: a
// send stops at the lowest free slot, or runs through the whole table when it
// is full; ack, tick and heard-from always sweep the whole table. Input stall
// stays high for the whole sweep. After reset the block clears every table
// slot before it takes the first word; configuration writes are taken at any
// time but must only be issued while the block is idle. Results leave in
// ascending slot order, the last word of each input carries last_o.
module retransmit_timeout_table
  import rtt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] peer_i,
  input  logic [31:0] ack_id_i,
  input  logic        is_ping_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [15:0] peer_out_o,
  output logic [31:0] seq_out_o,
  output logic        last_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] proc_idx_q, proc_idx_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d;
  logic          pv_q, pv_d;
  op_e           op_q, op_d;
  logic [15:0]   peer_q, peer_d;
  logic [31:0]   ack_id_q, ack_id_d;
  logic          is_ping_q, is_ping_d;
  logic          hd_v_q, hd_v_d;
  logic [15:0]   hd_peer_q, hd_peer_d;
  logic [31:0]   hd_seq_q, hd_seq_d;
  logic [31:0]   next_seq_q, next_seq_d;
  cfg_t          cfg_q, cfg_d;
  logic          out_valid_q, out_valid_d;
  kind_e         out_kind_q, out_kind_d;
  logic [15:0]   out_peer_q, out_peer_d;
  logic [31:0]   out_seq_q, out_seq_d;
  logic          out_last_q, out_last_d;

  entry_t        mem [TABLE_DEPTH];
  entry_t        rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  entry_t        mem_wd;

  logic          can_emit;
  logic [31:0]   new_seq;
  step_t         step;

  assign new_seq = next_seq_q + 32'd1;

  rtt_slot_unit u_slot (
    .op_i      (op_q),
    .peer_i    (peer_q),
    .ack_id_i  (ack_id_q),
    .is_ping_i (is_ping_q),
    .new_seq_i (new_seq),
    .cfg_i     (cfg_q),
    .entry_i   (rd_q),
    .step_o    (step)
  );

  assign can_emit    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign peer_out_o  = out_peer_q;
  assign seq_out_o   = out_seq_q;
  assign last_o      = out_last_q;

  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    proc_idx_d  = proc_idx_q;
    clr_idx_d   = clr_idx_q;
    pv_d        = pv_q;
    op_d        = op_q;
    peer_d      = peer_q;
    ack_id_d    = ack_id_q;
    is_ping_d   = is_ping_q;
    hd_v_d      = hd_v_q;
    hd_peer_d   = hd_peer_q;
    hd_seq_d    = hd_seq_q;
    next_seq_d  = next_seq_q;
    cfg_d       = cfg_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_peer_d  = out_peer_q;
    out_seq_d   = out_seq_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_wa      = proc_idx_q;
    mem_wd      = step.nxt;
    mem_re      = 1'b0;
    mem_ra      = rd_idx_q[AW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SELF_ID:    cfg_d.self_id    = cfg_data_i;
        CFG_DATA_WAIT:  cfg_d.data_wait  = cfg_data_i[7:0];
        CFG_DATA_TRIES: cfg_d.data_tries = cfg_data_i[3:0];
        CFG_PING_WAIT:  cfg_d.ping_wait  = cfg_data_i[7:0];
        CFG_PING_TRIES: cfg_d.ping_max   = cfg_data_i[3:0];
        default: cfg_d = cfg_q;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx_q;
        mem_wd = '0;
        if (clr_idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_e'(op_i);
          peer_d    = peer_i;
          ack_id_d  = ack_id_i;
          is_ping_d = is_ping_i;
          rd_idx_d  = '0;
          pv_d      = 1'b0;
          hd_v_d    = 1'b0;
          state_d   = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // advance only when a result word could be taken this cycle
        if (can_emit) begin
          if (pv_q) begin
            mem_we = step.wr;
            if (step.hit) begin
              // hold the latest ack match so the final one can carry last
              if (hd_v_q) begin
                out_valid_d = 1'b1;
                out_kind_d  = K_ACKED;
                out_peer_d  = hd_peer_q;
                out_seq_d   = hd_seq_q;
                out_last_d  = 1'b0;
              end
              hd_v_d    = 1'b1;
              hd_peer_d = rd_q.peer;
              hd_seq_d  = rd_q.seq;
            end else if (step.emit) begin
              out_valid_d = 1'b1;
              out_kind_d  = step.kind;
              out_peer_d  = step.nxt.peer;
              out_seq_d   = step.nxt.seq;
              out_last_d  = step.found;
            end
            if (step.found) begin
              next_seq_d = new_seq;
            end
          end
          if (pv_q && step.found) begin
            pv_d    = 1'b0;
            state_d = ST_IDLE;
          end else if (rd_idx_q != DEPTH_C) begin
            mem_re     = 1'b1;
            proc_idx_d = rd_idx_q[AW-1:0];
            pv_d       = 1'b1;
            rd_idx_d   = rd_idx_q + CW'(1);
          end else begin
            pv_d    = 1'b0;
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_seq_d   = '0;
          out_peer_d  = peer_q;
          case (op_q)
            OP_SEND: out_kind_d = K_FULL;
            OP_ACK: begin
              if (hd_v_q) begin
                out_kind_d = K_ACKED;
                out_peer_d = hd_peer_q;
                out_seq_d  = hd_seq_q;
              end else begin
                out_kind_d = K_UNMATCHED;
                out_seq_d  = ack_id_q;
              end
            end
            OP_TICK: begin
              out_kind_d = K_DONE;
              out_peer_d = '0;
            end
            OP_HEARD: out_kind_d = K_DONE;
            default: out_kind_d = K_DONE;
          endcase
          hd_v_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_CLEAR;
      rd_idx_q         <= '0;
      proc_idx_q       <= '0;
      clr_idx_q        <= '0;
      pv_q             <= 1'b0;
      op_q             <= OP_SEND;
      peer_q           <= '0;
      ack_id_q         <= '0;
      is_ping_q        <= 1'b0;
      hd_v_q           <= 1'b0;
      hd_peer_q        <= '0;
      hd_seq_q         <= '0;
      next_seq_q       <= '0;
      cfg_q.self_id    <= 16'd0;
      cfg_q.data_wait  <= 8'd10;
      cfg_q.data_tries <= 4'd4;
      cfg_q.ping_wait  <= 8'd20;
      cfg_q.ping_max   <= 4'd4;
      out_valid_q      <= 1'b0;
      out_kind_q       <= K_QUEUED;
      out_peer_q       <= '0;
      out_seq_q        <= '0;
      out_last_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      proc_idx_q  <= proc_idx_d;
      clr_idx_q   <= clr_idx_d;
      pv_q        <= pv_d;
      op_q        <= op_d;
      peer_q      <= peer_d;
      ack_id_q    <= ack_id_d;
      is_ping_q   <= is_ping_d;
      hd_v_q      <= hd_v_d;
      hd_peer_q   <= hd_peer_d;
      hd_seq_q    <= hd_seq_d;
      next_seq_q  <= next_seq_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_peer_q  <= out_peer_d;
      out_seq_q   <= out_seq_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

`ifndef SYNTHESIS
  a_accept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted word did not start a sweep");

  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !hd_v_q)
    else $error("held ack match left over in idle");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_wa != mem_ra)
    else $error("table read and write hit the same slot");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == K_QUEUED || kind_o == K_FULL ||
                    kind_o == K_UNMATCHED || kind_o == K_DONE) |-> last_o)
    else $error("single or closing result without last");
`endif

endmodule
